@@ hdl/kvp_pkg.sv @@
// ----------------------------------------------------------------------------
// kvp_pkg
// Shared types and constants for the quoted key/value line parser.
// ----------------------------------------------------------------------------
package kvp_pkg;

    // parse phases
    localparam logic [3:0] PH_KEY      = 4'd0;
    localparam logic [3:0] PH_VALSTART = 4'd1;
    localparam logic [3:0] PH_UNQ      = 4'd2;
    localparam logic [3:0] PH_QUOTED   = 4'd3;
    localparam logic [3:0] PH_ESC      = 4'd4;
    localparam logic [3:0] PH_OCT      = 4'd5;
    localparam logic [3:0] PH_AFTERQ   = 4'd6;
    localparam logic [3:0] PH_SKIP     = 4'd7;

    // result kinds
    localparam logic [2:0] K_KEY     = 3'd0;
    localparam logic [2:0] K_VAL     = 3'd1;
    localparam logic [2:0] K_COMMIT  = 3'd2;
    localparam logic [2:0] K_DISCARD = 3'd3;
    localparam logic [2:0] K_ACCEPT  = 3'd4;
    localparam logic [2:0] K_REJECT  = 3'd5;

    // characters
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SP    = 8'h20;

    // results per item and result queue sizing
    localparam int RES_MAX    = 3;
    localparam int RES_CW     = $clog2(RES_MAX + 1);
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [3:0] phase;
        logic       key_started;
        logic [7:0] oct_val;
        logic [1:0] oct_dig;
        logic       oct_hi;
    } t_state;

    typedef struct packed {
        logic [7:0] data;
        logic [2:0] kind;
        logic       last;
    } t_res;

    typedef struct packed {
        logic [RES_CW-1:0] cnt;
        logic              pop;
    } t_qctl;

    typedef struct packed {
        logic [FIFO_CW-1:0] space;
        logic               nonempty;
    } t_qsts;

endpackage

@@ hdl/kvp_step.sv @@
// ----------------------------------------------------------------------------
// kvp_step
// Next-state and result list for one line byte against the parse state.
// ----------------------------------------------------------------------------
module kvp_step
    import kvp_pkg::*;
(
    input  t_state            i_st,
    input  logic [7:0]        i_char,
    input  logic              i_last,
    output t_state            o_st,
    output t_res              o_res [RES_MAX],
    output logic [RES_CW-1:0] o_cnt
);

    t_state            nx;
    t_res              res [RES_MAX];
    logic [RES_CW-1:0] n;
    logic              is_oct;
    logic              reject;
    logic [1:0]        dig_n;
    logic [7:0]        val_n;
    logic [1:0]        lim;

    always_comb begin
        nx     = i_st;
        n      = '0;
        reject = 1'b0;
        for (int k = 0; k < RES_MAX; k++) begin
            res[k] = '0;
        end
        is_oct = (i_char >= CH_0) && (i_char <= CH_7);
        dig_n  = i_st.oct_dig + 2'd1;
        val_n  = {i_st.oct_val[4:0], i_char[2:0]};
        lim    = i_st.oct_hi ? 2'd2 : 2'd3;

        case (i_st.phase)
            PH_VALSTART: begin
                if (i_char == CH_QUOTE) begin
                    nx.phase = PH_QUOTED;
                end else if (i_char == CH_SP) begin
                    res[n] = '{data: 8'd0, kind: K_COMMIT, last: 1'b0};
                    n = n + 1'b1;
                    nx.key_started = 1'b0;
                    nx.phase = PH_KEY;
                end else begin
                    res[n] = '{data: i_char, kind: K_VAL, last: 1'b0};
                    n = n + 1'b1;
                    nx.phase = PH_UNQ;
                end
            end
            PH_UNQ: begin
                if (i_char == CH_SP) begin
                    res[n] = '{data: 8'd0, kind: K_COMMIT, last: 1'b0};
                    n = n + 1'b1;
                    nx.key_started = 1'b0;
                    nx.phase = PH_KEY;
                end else begin
                    res[n] = '{data: i_char, kind: K_VAL, last: 1'b0};
                    n = n + 1'b1;
                end
            end
            PH_QUOTED: begin
                if (i_char == CH_QUOTE) begin
                    res[n] = '{data: 8'd0, kind: K_COMMIT, last: 1'b0};
                    n = n + 1'b1;
                    nx.key_started = 1'b0;
                    nx.phase = PH_AFTERQ;
                end else if (i_char == CH_BSL) begin
                    nx.phase = PH_ESC;
                end else begin
                    res[n] = '{data: i_char, kind: K_VAL, last: 1'b0};
                    n = n + 1'b1;
                end
            end
            PH_ESC: begin
                nx.phase = PH_QUOTED;
                if (i_char == CH_N) begin
                    res[n] = '{data: CH_LF, kind: K_VAL, last: 1'b0};
                    n = n + 1'b1;
                end else if (i_char == CH_T) begin
                    res[n] = '{data: CH_TAB, kind: K_VAL, last: 1'b0};
                    n = n + 1'b1;
                end else if (i_char == CH_R) begin
                    res[n] = '{data: CH_CR, kind: K_VAL, last: 1'b0};
                    n = n + 1'b1;
                end else if (is_oct) begin
                    nx.oct_val = {5'd0, i_char[2:0]};
                    nx.oct_dig = 2'd1;
                    nx.oct_hi  = (i_char > CH_3);
                    nx.phase   = PH_OCT;
                end else begin
                    res[n] = '{data: i_char, kind: K_VAL, last: 1'b0};
                    n = n + 1'b1;
                end
            end
            PH_OCT: begin
                if (is_oct) begin
                    nx.oct_val = val_n;
                    nx.oct_dig = dig_n;
                    if (dig_n >= lim) begin
                        res[n] = '{data: val_n, kind: K_VAL, last: 1'b0};
                        n = n + 1'b1;
                        nx.oct_val = '0;
                        nx.oct_dig = '0;
                        nx.oct_hi  = 1'b0;
                        nx.phase   = PH_QUOTED;
                    end
                end else begin
                    res[n] = '{data: i_st.oct_val, kind: K_VAL, last: 1'b0};
                    n = n + 1'b1;
                    nx.oct_val = '0;
                    nx.oct_dig = '0;
                    nx.oct_hi  = 1'b0;
                    nx.phase   = PH_QUOTED;
                    // cut-short escape: byte goes through the quoted-string path
                    if (i_char == CH_QUOTE) begin
                        res[n] = '{data: 8'd0, kind: K_COMMIT, last: 1'b0};
                        n = n + 1'b1;
                        nx.key_started = 1'b0;
                        nx.phase = PH_AFTERQ;
                    end else if (i_char == CH_BSL) begin
                        nx.phase = PH_ESC;
                    end else begin
                        res[n] = '{data: i_char, kind: K_VAL, last: 1'b0};
                        n = n + 1'b1;
                    end
                end
            end
            PH_AFTERQ: begin
                nx.phase = PH_KEY;
                if (i_char == CH_EQ) begin
                    nx.phase = PH_VALSTART;
                end else if (i_char != CH_SP) begin
                    res[n] = '{data: i_char, kind: K_KEY, last: 1'b0};
                    n = n + 1'b1;
                    nx.key_started = 1'b1;
                end
            end
            PH_SKIP: begin
                nx.phase = PH_SKIP;
            end
            default: begin
                nx.phase = PH_KEY;
                if (i_char == CH_EQ) begin
                    nx.phase = PH_VALSTART;
                end else if (i_char == CH_SP) begin
                    if (i_st.key_started) begin
                        res[n] = '{data: 8'd0, kind: K_DISCARD, last: 1'b0};
                        n = n + 1'b1;
                    end
                    nx.key_started = 1'b0;
                    nx.phase = PH_SKIP;
                end else begin
                    res[n] = '{data: i_char, kind: K_KEY, last: 1'b0};
                    n = n + 1'b1;
                    nx.key_started = 1'b1;
                end
            end
        endcase

        if (i_last) begin
            case (nx.phase)
                PH_VALSTART, PH_UNQ: begin
                    res[n] = '{data: 8'd0, kind: K_COMMIT, last: 1'b0};
                    n = n + 1'b1;
                end
                PH_QUOTED, PH_ESC, PH_OCT: reject = 1'b1;
                PH_AFTERQ, PH_SKIP:        reject = 1'b0;
                default:                   reject = nx.key_started;
            endcase
            if (reject) begin
                res[0] = '{data: 8'd0, kind: K_DISCARD, last: 1'b0};
                res[1] = '{data: 8'd0, kind: K_REJECT, last: 1'b0};
                n = RES_CW'(2);
            end else begin
                res[n] = '{data: 8'd0, kind: K_ACCEPT, last: 1'b0};
                n = n + 1'b1;
            end
            nx = '{phase: PH_KEY, key_started: 1'b0, oct_val: 8'd0,
                   oct_dig: 2'd0, oct_hi: 1'b0};
        end

        if (n != '0) begin
            res[n - 1'b1].last = 1'b1;
        end
    end

    assign o_st  = nx;
    assign o_res = res;
    assign o_cnt = n;

endmodule

@@ hdl/kvp_fifo.sv @@
// ----------------------------------------------------------------------------
// kvp_fifo
// Result queue: takes up to three results per cycle, hands out one.
// ----------------------------------------------------------------------------
module kvp_fifo
    import kvp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_qctl i_ctl,
    input  t_res  i_res [RES_MAX],
    output t_qsts o_sts,
    output t_res  o_head
);

    t_res               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr;
    logic [FIFO_AW-1:0] r_rd;
    logic [FIFO_CW-1:0] r_count;
    logic [FIFO_AW-1:0] n_wr;
    logic [FIFO_AW-1:0] n_rd;
    logic [FIFO_CW-1:0] n_count;

    always_comb begin
        n_wr    = r_wr + FIFO_AW'(i_ctl.cnt);
        n_rd    = r_rd + FIFO_AW'(i_ctl.pop);
        n_count = r_count + FIFO_CW'(i_ctl.cnt) - FIFO_CW'(i_ctl.pop);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < RES_MAX; k++) begin
            if (RES_CW'(k) < i_ctl.cnt) begin
                r_mem[r_wr + FIFO_AW'(k)] <= i_res[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    assign o_sts.space    = FIFO_CW'(FIFO_DEPTH) - r_count;
    assign o_sts.nonempty = (r_count != '0);
    assign o_head         = r_mem[r_rd];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        FIFO_CW'(i_ctl.cnt) <= o_sts.space)
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.pop |-> r_count != '0)
        else $error("result queue underflow");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        FIFO_AW'(r_wr - r_rd) == FIFO_AW'(r_count))
        else $error("queue pointers disagree with count");

endmodule

@@ hdl/quoted_key_value_parser_top.sv @@
// ----------------------------------------------------------------------------
// quoted_key_value_parser_top
// Streaming KEY=VALUE / KEY="quoted" line parser, one byte per item.
//
//   channel | handshake           | payload
//   --------+---------------------+--------------------------------------
//   in      | i_valid / o_ready   | i_char_in, i_line_last
//   out     | o_valid / i_ready   | o_out_byte, o_kind, o_last_of_item
//
// One byte per cycle into the parse register; the step logic clears it in
// the next cycle when the result queue has room for its results.
// Each byte yields zero to three results, drained from an 8-entry queue one
// per cycle while i_ready is high, so output is at most one result per cycle.
// Bytes are held in the input register and results in the result queue.
// Synchronous active-low reset returns the parser to the key phase.
// ----------------------------------------------------------------------------
module quoted_key_value_parser_top
    import kvp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_in,
    input  logic       i_line_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_kind,
    output logic       o_last_of_item
);

    logic       r_in_vld;
    logic [7:0] r_in_char;
    logic       r_in_last;
    t_state     r_st;
    t_state     n_st;

    t_res              step_res [RES_MAX];
    logic [RES_CW-1:0] step_cnt;
    logic              take;
    t_qctl             qctl;
    t_qsts             qsts;
    t_res              head;

    kvp_step u_step (
        .i_st   (r_st),
        .i_char (r_in_char),
        .i_last (r_in_last),
        .o_st   (n_st),
        .o_res  (step_res),
        .o_cnt  (step_cnt)
    );

    assign take     = r_in_vld && (FIFO_CW'(step_cnt) <= qsts.space);
    assign o_ready  = !r_in_vld || take;
    assign qctl.cnt = take ? step_cnt : '0;
    assign qctl.pop = qsts.nonempty && i_ready;

    kvp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (qctl),
        .i_res   (step_res),
        .o_sts   (qsts),
        .o_head  (head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_st     <= '{phase: PH_KEY, key_started: 1'b0, oct_val: 8'd0,
                          oct_dig: 2'd0, oct_hi: 1'b0};
        end else begin
            if (o_ready) begin
                r_in_vld <= i_valid;
            end
            if (take) begin
                r_st <= n_st;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_char <= i_char_in;
            r_in_last <= i_line_last;
        end
    end

    assign o_valid        = qsts.nonempty;
    assign o_out_byte     = head.data;
    assign o_kind         = head.kind;
    assign o_last_of_item = head.last;

    a_line_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && r_in_last |=> r_st.phase == PH_KEY && !r_st.key_started)
        else $error("parse state not cleared at line end");

    a_end_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && r_in_last |-> step_cnt != '0)
        else $error("line end produced no result");

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !take |=> $stable(r_st))
        else $error("parse state moved without a byte");

endmodule

@@ bench/tb_quoted_key_value_parser_top.sv @@
// ----------------------------------------------------------------------------
// tb_quoted_key_value_parser_top
// Self-checking bench for the quoted key/value line parser. A line-level
// predictor tracks the parse state for every accepted byte and queues the
// key, value and marker items it should produce. Each output item is checked
// in order against that queue. A short directed set of lines is followed by
// random well-formed, truncated and noise lines, under varying idle and stall
// pressure on both channels.
// ----------------------------------------------------------------------------
module tb_quoted_key_value_parser_top
    import kvp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_ITEMS = 230;

    class parse_scoreboard;
        t_res        expected_q[$];
        int unsigned mismatches;
        logic [3:0]  phase;
        logic        key_started;
        logic [7:0]  oct_val;
        logic [1:0]  oct_dig;
        logic        oct_hi;
        t_res        step_res[3];
        int          step_n;

        function new();
            mismatches = 0;
            step_n     = 0;
            clear();
        endfunction

        function void clear();
            phase       = PH_KEY;
            key_started = 1'b0;
            oct_val     = 8'd0;
            oct_dig     = 2'd0;
            oct_hi      = 1'b0;
        endfunction

        function void add(logic [7:0] b, logic [2:0] k);
            if (step_n < RES_MAX) begin
                step_res[step_n] = '{data: b, kind: k, last: 1'b0};
                step_n++;
            end
        endfunction

        function void key_char(logic [7:0] c);
            if (c == CH_EQ) begin
                phase = PH_VALSTART;
            end else if (c == CH_SP) begin
                if (key_started)
                    add(8'd0, K_DISCARD);
                key_started = 1'b0;
                phase = PH_SKIP;
            end else begin
                add(c, K_KEY);
                key_started = 1'b1;
            end
        endfunction

        function void quoted_char(logic [7:0] c);
            if (c == CH_QUOTE) begin
                add(8'd0, K_COMMIT);
                key_started = 1'b0;
                phase = PH_AFTERQ;
            end else if (c == CH_BSL) begin
                phase = PH_ESC;
            end else begin
                add(c, K_VAL);
            end
        endfunction

        function void take_char(logic [7:0] c);
            logic       is_oct;
            logic [7:0] digit;
            int         lim;
            is_oct = (c >= CH_0) && (c <= CH_7);
            digit  = c - CH_0;
            case (phase)
                PH_VALSTART: begin
                    if (c == CH_QUOTE) begin
                        phase = PH_QUOTED;
                    end else if (c == CH_SP) begin
                        add(8'd0, K_COMMIT);
                        key_started = 1'b0;
                        phase = PH_KEY;
                    end else begin
                        add(c, K_VAL);
                        phase = PH_UNQ;
                    end
                end
                PH_UNQ: begin
                    if (c == CH_SP) begin
                        add(8'd0, K_COMMIT);
                        key_started = 1'b0;
                        phase = PH_KEY;
                    end else begin
                        add(c, K_VAL);
                    end
                end
                PH_QUOTED: quoted_char(c);
                PH_ESC: begin
                    phase = PH_QUOTED;
                    if (c == CH_N) begin
                        add(CH_LF, K_VAL);
                    end else if (c == CH_T) begin
                        add(CH_TAB, K_VAL);
                    end else if (c == CH_R) begin
                        add(CH_CR, K_VAL);
                    end else if (is_oct) begin
                        oct_val = digit;
                        oct_dig = 2'd1;
                        oct_hi  = (c > CH_3);
                        phase   = PH_OCT;
                    end else begin
                        add(c, K_VAL);
                    end
                end
                PH_OCT: begin
                    if (is_oct) begin
                        lim     = oct_hi ? 2 : 3;
                        oct_val = {oct_val[4:0], 3'b000} + digit;
                        oct_dig = oct_dig + 2'd1;
                        if (int'(oct_dig) >= lim) begin
                            add(oct_val, K_VAL);
                            oct_val = 8'd0;
                            oct_dig = 2'd0;
                            oct_hi  = 1'b0;
                            phase   = PH_QUOTED;
                        end
                    end else begin
                        add(oct_val, K_VAL);
                        oct_val = 8'd0;
                        oct_dig = 2'd0;
                        oct_hi  = 1'b0;
                        phase   = PH_QUOTED;
                        quoted_char(c);
                    end
                end
                PH_AFTERQ: begin
                    phase = PH_KEY;
                    if (c != CH_SP)
                        key_char(c);
                end
                PH_SKIP: ;
                default: begin
                    phase = PH_KEY;
                    key_char(c);
                end
            endcase
        endfunction

        function void end_line();
            logic reject;
            reject = 1'b0;
            case (phase)
                PH_VALSTART, PH_UNQ: add(8'd0, K_COMMIT);
                PH_QUOTED, PH_ESC, PH_OCT: reject = 1'b1;
                PH_AFTERQ, PH_SKIP: ;
                default: reject = key_started;
            endcase
            if (reject) begin
                step_n = 0;
                add(8'd0, K_DISCARD);
                add(8'd0, K_REJECT);
            end else begin
                add(8'd0, K_ACCEPT);
            end
            clear();
        endfunction

        function void note_byte(logic [7:0] c, logic last);
            step_n = 0;
            take_char(c);
            if (last)
                end_line();
            if (step_n > 0)
                step_res[step_n-1].last = 1'b1;
            for (int i = 0; i < step_n; i++)
                expected_q = {expected_q, step_res[i]};
        endfunction

        function void check_result(logic [7:0] b, logic [2:0] k, logic l);
            t_res exp_r;
            if (expected_q.size() == 0) begin
                $error("unexpected item: out_byte %0h kind %0d last_of_item %0b", b, k, l);
                mismatches++;
                return;
            end
            exp_r = expected_q[0];
            expected_q.delete(0);
            if (b !== exp_r.data) begin
                $error("out_byte: expected %0h actual %0h", exp_r.data, b);
                mismatches++;
            end
            if (k !== exp_r.kind) begin
                $error("kind: expected %0d actual %0d", exp_r.kind, k);
                mismatches++;
            end
            if (l !== exp_r.last) begin
                $error("last_of_item: expected %0b actual %0b", exp_r.last, l);
                mismatches++;
            end
        endfunction
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic [7:0] i_char_in   = 8'd0;
    logic       i_line_last = 1'b0;
    logic       i_ready     = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic [2:0] o_kind;
    logic       o_last_of_item;

    parse_scoreboard sb = new();
    logic [7:0]      line_bytes[$];
    int              sent         = 0;
    int              tx_idle_pct  = 0;
    int              rx_stall_pct = 0;

    quoted_key_value_parser_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_char_in      (i_char_in),
        .i_line_last    (i_line_last),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_byte     (o_out_byte),
        .o_kind         (o_kind),
        .o_last_of_item (o_last_of_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                sb.note_byte(i_char_in, i_line_last);
            if (o_valid && i_ready)
                sb.check_result(o_out_byte, o_kind, o_last_of_item);
        end
    end

    function automatic void put_byte(logic [7:0] b);
        line_bytes = {line_bytes, b};
    endfunction

    function automatic logic [7:0] pick_char();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 8'h61 + 8'($urandom_range(0, 25));
        if (r < 55)
            return CH_0 + 8'($urandom_range(0, 9));
        if (r < 75) begin
            case ($urandom_range(0, 7))
                0: return CH_QUOTE;
                1: return CH_BSL;
                2: return CH_EQ;
                3: return CH_SP;
                4: return CH_N;
                5: return CH_T;
                6: return CH_R;
                default: return CH_7;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_excluding(logic [7:0] x0, logic [7:0] x1);
        logic [7:0] c;
        c = pick_char();
        while (c == x0 || c == x1)
            c = pick_char();
        return c;
    endfunction

    function automatic void push_quoted();
        int n;
        int r;
        n = $urandom_range(0, 5);
        put_byte(CH_QUOTE);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                put_byte(pick_excluding(CH_QUOTE, CH_BSL));
            end else if (r < 65) begin
                put_byte(CH_BSL);
                case ($urandom_range(0, 2))
                    0: put_byte(CH_N);
                    1: put_byte(CH_T);
                    default: put_byte(CH_R);
                endcase
            end else if (r < 85) begin
                put_byte(CH_BSL);
                repeat ($urandom_range(1, 3))
                    put_byte(CH_0 + 8'($urandom_range(0, 7)));
            end else begin
                put_byte(CH_BSL);
                put_byte(pick_char());
            end
        end
        put_byte(CH_QUOTE);
    endfunction

    function automatic void push_pair();
        repeat ($urandom_range(1, 4))
            put_byte(pick_excluding(CH_EQ, CH_SP));
        put_byte(CH_EQ);
        case ($urandom_range(0, 3))
            0: ;
            1: repeat ($urandom_range(1, 5))
                   put_byte(pick_excluding(CH_SP, CH_SP));
            default: push_quoted();
        endcase
    endfunction

    function automatic void build_line();
        int r;
        int cut;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            repeat ($urandom_range(1, 8))
                put_byte(8'($urandom_range(0, 255)));
            return;
        end
        for (int i = 0; i < $urandom_range(0, 3); i++) begin
            if (i > 0 && $urandom_range(0, 3) != 0)
                put_byte(CH_SP);
            push_pair();
        end
        if ($urandom_range(0, 9) < 3) begin
            put_byte(CH_SP);
            repeat ($urandom_range(1, 6))
                put_byte(pick_char());
        end
        if (line_bytes.size() == 0)
            put_byte(pick_char());
        if (r < 30 && line_bytes.size() > 1) begin
            cut = $urandom_range(0, line_bytes.size() - 2);
            line_bytes = line_bytes[0:cut];
        end
    endfunction

    function automatic void load_str(string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endfunction

    task automatic send_line();
        for (int i = 0; i < line_bytes.size(); i++) begin
            while ($urandom_range(0, 99) < tx_idle_pct) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
            i_valid     <= 1'b1;
            i_char_in   <= line_bytes[i];
            i_line_last <= (i == line_bytes.size() - 1);
            @(posedge i_clk);
            while (!o_ready)
                @(posedge i_clk);
            sent++;
        end
        line_bytes.delete();
    endtask

    initial begin
        int guard;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // tab and octal escapes, lead-high octal, octal cut by quote,
        // key right after closing quote, line ending after '='
        load_str("k=\"\\t\\477\\0\"z=");
        send_line();
        // byte extremes, unquoted value, line ending inside a key
        line_bytes = '{8'hFF, CH_EQ, 8'h00, CH_SP, 8'h71};
        send_line();
        // space ending a key, rest of line ignored
        load_str("x y");
        send_line();
        // line ending inside an open quoted string
        load_str("=\"\\r");
        send_line();

        while (sent < N_ITEMS) begin
            case (sent * 4 / N_ITEMS)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 83; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 83; end
                default: begin tx_idle_pct = 13; rx_stall_pct = 13; end
            endcase
            build_line();
            send_line();
        end
        i_valid <= 1'b0;

        guard = 0;
        while (sb.expected_q.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #2ms;
        $display("FAILURE");
        $finish;
    end

endmodule
